// ===== design/dnsq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsq_pkg
// Shared types and constants for the DNS question name parser.
// ----------------------------------------------------------------------------
package dnsq_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] DOT_CHAR  = 8'h2e;
  localparam logic [2:0] SKIP_BYTES = 3'd4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_NAME,
    PH_SKIP
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_END    = 2'd2,
    KIND_ERROR  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_out;
    logic [15:0] question_index;
    logic [15:0] message_id;
    logic [15:0] question_count;
    logic        last_name;
  } result_t;

endpackage

// ===== design/dnsq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsq_front
// Byte parser: tracks header and name state, classifies each beat and
// produces at most one result per accepted beat.
// ----------------------------------------------------------------------------
module dnsq_front #(
  parameter int MAX_NAME_CHARS = 255
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       msg_byte,
  input  logic             msg_start,
  output logic             res_valid,
  output dnsq_pkg::result_t res
);

  localparam logic [7:0] MAX_LEN = 8'(MAX_NAME_CHARS);

  dnsq_pkg::phase_t phase, phase_next;
  logic [3:0]  header_position, header_position_next;
  logic [15:0] held_id, held_id_next;
  logic [15:0] held_count, held_count_next;
  logic [15:0] current_question, current_question_next;
  logic [6:0]  label_remaining, label_remaining_next;
  logic        first_label, first_label_next;
  logic [7:0]  name_length, name_length_next;
  logic [2:0]  skip_remaining, skip_remaining_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= dnsq_pkg::PH_IDLE;
      header_position  <= '0;
      held_id          <= '0;
      held_count       <= '0;
      current_question <= '0;
      label_remaining  <= '0;
      first_label      <= 1'b1;
      name_length      <= '0;
      skip_remaining   <= '0;
    end else begin
      phase            <= phase_next;
      header_position  <= header_position_next;
      held_id          <= held_id_next;
      held_count       <= held_count_next;
      current_question <= current_question_next;
      label_remaining  <= label_remaining_next;
      first_label      <= first_label_next;
      name_length      <= name_length_next;
      skip_remaining   <= skip_remaining_next;
    end
  end

  always_comb begin
    dnsq_pkg::phase_t ph;
    logic [3:0] hp;
    logic       pc_en;
    logic [7:0] pc_ch;
    logic [15:0] q_inc;

    phase_next            = phase;
    header_position_next  = header_position;
    held_id_next          = held_id;
    held_count_next       = held_count;
    current_question_next = current_question;
    label_remaining_next  = label_remaining;
    first_label_next      = first_label;
    name_length_next      = name_length;
    skip_remaining_next   = skip_remaining;
    res_valid             = 1'b0;
    res.kind              = dnsq_pkg::KIND_HEADER;
    res.char_out          = '0;
    res.question_index    = '0;
    res.last_name         = 1'b0;
    pc_en                 = 1'b0;
    pc_ch                 = '0;
    q_inc                 = current_question + 16'd1;
    ph                    = phase;
    hp                    = header_position;

    if (fire) begin
      if (msg_start) begin
        ph = dnsq_pkg::PH_HEADER;
        hp = '0;
        phase_next = dnsq_pkg::PH_HEADER;
        header_position_next = '0;
      end
      unique case (ph)
        dnsq_pkg::PH_HEADER: begin
          case (hp)
            4'd0: held_id_next[15:8]    = msg_byte;
            4'd1: held_id_next[7:0]     = msg_byte;
            4'd4: held_count_next[15:8] = msg_byte;
            4'd5: held_count_next[7:0]  = msg_byte;
            default: ;
          endcase
          if (hp >= 4'(dnsq_pkg::HEADER_BYTES - 1)) begin
            header_position_next  = '0;
            current_question_next = '0;
            if (held_count_next == 16'd0) begin
              phase_next = dnsq_pkg::PH_IDLE;
            end else begin
              phase_next           = dnsq_pkg::PH_NAME;
              label_remaining_next = '0;
              first_label_next     = 1'b1;
              name_length_next     = '0;
            end
            res_valid = 1'b1;
            res.kind  = dnsq_pkg::KIND_HEADER;
          end else begin
            header_position_next = hp + 4'd1;
          end
        end
        dnsq_pkg::PH_NAME: begin
          res.question_index = current_question;
          if (msg_byte == 8'd0) begin
            res_valid = 1'b1;
            if (name_length == 8'd0) begin
              phase_next = dnsq_pkg::PH_IDLE;
              res.kind   = dnsq_pkg::KIND_ERROR;
            end else begin
              if (q_inc == held_count) begin
                phase_next    = dnsq_pkg::PH_IDLE;
                res.last_name = 1'b1;
              end else begin
                phase_next          = dnsq_pkg::PH_SKIP;
                skip_remaining_next = dnsq_pkg::SKIP_BYTES;
              end
              label_remaining_next = '0;
              res.kind = dnsq_pkg::KIND_END;
            end
          end else if (label_remaining == 7'd0) begin
            label_remaining_next = msg_byte[7] ? 7'd0 : msg_byte[6:0];
            if (first_label) begin
              first_label_next = 1'b0;
            end else begin
              pc_en = 1'b1;
              pc_ch = dnsq_pkg::DOT_CHAR;
            end
          end else begin
            label_remaining_next = label_remaining - 7'd1;
            pc_en = 1'b1;
            pc_ch = msg_byte;
          end
        end
        dnsq_pkg::PH_SKIP: begin
          skip_remaining_next = skip_remaining - 3'd1;
          if (skip_remaining_next == 3'd0) begin
            current_question_next = q_inc;
            phase_next            = dnsq_pkg::PH_NAME;
            label_remaining_next  = '0;
            first_label_next      = 1'b1;
            name_length_next      = '0;
          end
        end
        default: phase_next = dnsq_pkg::PH_IDLE;
      endcase

      if (pc_en) begin
        res_valid = 1'b1;
        if (name_length >= MAX_LEN) begin
          phase_next = dnsq_pkg::PH_IDLE;
          res.kind   = dnsq_pkg::KIND_ERROR;
        end else begin
          name_length_next = name_length + 8'd1;
          res.kind         = dnsq_pkg::KIND_CHAR;
          res.char_out     = pc_ch;
        end
      end
    end

    res.message_id     = held_id_next;
    res.question_count = held_count_next;
  end

  a_res_needs_beat: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> fire) else $error("result without an accepted beat");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == dnsq_pkg::PH_SKIP |-> skip_remaining != 3'd0)
    else $error("skip phase with nothing left to skip");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    name_length <= MAX_LEN) else $error("name length past maximum");

endmodule

// ===== design/dnsq_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsq_queue
// Small result FIFO between the parser and the output stage.
// ----------------------------------------------------------------------------
module dnsq_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dnsq_pkg::result_t push_data,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output dnsq_pkg::result_t head
);

  dnsq_pkg::result_t entries [dnsq_pkg::QUEUE_DEPTH];
  logic [dnsq_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [dnsq_pkg::QCNT_W-1:0] count;

  assign full      = (count == dnsq_pkg::QCNT_W'(dnsq_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + dnsq_pkg::QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + dnsq_pkg::QPTR_W'(1);
      count <= count + dnsq_pkg::QCNT_W'(push) - dnsq_pkg::QCNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full || pop) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("pop from empty queue");

endmodule

// ===== design/dnsq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsq_back
// Output register stage: takes results from the queue and drives the
// master-side stream.
// ----------------------------------------------------------------------------
module dnsq_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  dnsq_pkg::result_t q_head,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [55:0]       m_tdata,
  output logic [1:0]        m_tuser,
  output logic              m_tlast
);

  dnsq_pkg::result_t out_reg;

  assign q_pop = q_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) out_reg <= q_head;
  end

  assign m_tdata = {out_reg.question_count, out_reg.message_id,
                    out_reg.question_index, out_reg.char_out};
  assign m_tuser = out_reg.kind;
  assign m_tlast = out_reg.last_name;

endmodule

// ===== design/dns_question_name_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dns_question_name_parser_top
// Decodes DNS question names from a byte stream into characters and events.
// ----------------------------------------------------------------------------
// With an empty queue, a result goes through the queue into the output register.
// Throughput: 1 byte/cycle; the 4-entry result queue absorbs output stalls until full.
// s_tready drops only while the result queue is full.
// Reset (rst, synchronous) returns the parser to idle and empties the queue.
// ----------------------------------------------------------------------------
module dns_question_name_parser_top #(
  parameter int MAX_NAME_CHARS = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] msg_byte
  input  logic        s_tuser,   // [0] msg_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [7:0] char_out, [23:8] question_index,
                                 // [39:24] message_id, [55:40] question_count
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast    // last_name
);

  logic              fire;
  logic              res_valid;
  dnsq_pkg::result_t res;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  dnsq_pkg::result_t q_head;

  assign s_tready = !q_full;
  assign fire     = s_tvalid && s_tready;

  dnsq_front #(
    .MAX_NAME_CHARS(MAX_NAME_CHARS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .msg_byte  (s_tdata),
    .msg_start (s_tuser),
    .res_valid (res_valid),
    .res       (res)
  );

  dnsq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  dnsq_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
